// File: sv/degc_pkg.sv
`default_nettype none

package degc_pkg;

  // Storage sizes
  localparam int MaxSegments  = 4;
  localparam int MaxReactions = 8;
  localparam int SplineWords  = 9;
  localparam int SplineDepth  = MaxSegments * SplineWords;
  localparam int TableDepth   = 2 * MaxReactions;

  // Iteration counts of the log and exp units
  localparam int LnRounds     = 20;
  localparam int HornerTerms  = 10;

  // Fixed-point constants
  localparam logic [30:0] Ln2Q30   = 31'd744261118;
  localparam logic [30:0] Log2eQ30 = 31'd1549082005;
  localparam logic [31:0] OneQ30   = 32'h4000_0000;
  localparam logic [23:0] GainMax  = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_SPLINE,
    CMD_ATTACK,
    CMD_RELEASE
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_SPLINE_COUNT,
    CFG_ATTACK_COUNT,
    CFG_RELEASE_COUNT,
    CFG_MIN_LEVEL
  } cfg_idx_e;

  // Datapath operations, one per cycle
  typedef enum logic [5:0] {
    OP_NONE,
    OP_ACC,
    OP_TRD,
    OP_TUSE,
    OP_EMUL,
    OP_EUPD,
    OP_NORM,
    OP_SQM,
    OP_SQU,
    OP_LNM,
    OP_LNU,
    OP_WLD,
    OP_SDIF,
    OP_SLM,
    OP_SLU,
    OP_SQ1M,
    OP_SQ1U,
    OP_SQ2M,
    OP_SQ2U,
    OP_SACC,
    OP_XM,
    OP_XSAT,
    OP_XT,
    OP_XFM,
    OP_XFU,
    OP_HM,
    OP_HV,
    OP_HRM,
    OP_HRQ,
    OP_HRC,
    OP_HE,
    OP_XG,
    OP_FIN
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_TRD,
    ST_TUSE,
    ST_EMUL,
    ST_EUPD,
    ST_NORM,
    ST_SQM,
    ST_SQU,
    ST_LNM,
    ST_LNU,
    ST_WLD,
    ST_SDIF,
    ST_SLM,
    ST_SLU,
    ST_SQ1M,
    ST_SQ1U,
    ST_SQ2M,
    ST_SQ2U,
    ST_SACC,
    ST_XM,
    ST_XSAT,
    ST_XT,
    ST_XFM,
    ST_XFU,
    ST_HM,
    ST_HV,
    ST_HRM,
    ST_HRQ,
    ST_HRC,
    ST_HE,
    ST_XG,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] cnt;
    logic [1:0] seg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [3:0] tab_n;
    logic [2:0] seg_n;
    logic       norm_done;
    logic       lin;
    logic       x_sat;
  } dp_stat_t;

  // floor(2^32 / n) for the Horner divisors two to ten
  function automatic logic [31:0] recip(input logic [3:0] n);
    logic [31:0] r;
    unique case (n)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/degc_ram.sv
`default_nettype none

module degc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/degc_ctrl.sv
`default_nettype none

module degc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           cmd_i,
  input  wire logic                 out_stall_i,
  input  wire degc_pkg::dp_stat_t   stat_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  output degc_pkg::ctrl_cmd_t       cmd_o
);

  degc_pkg::state_e state_q, state_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [1:0]       seg_q, seg_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid_i && (state_q == degc_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and counters
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    seg_d   = seg_q;
    unique case (state_q)
      degc_pkg::ST_IDLE: begin
        if (accept && (degc_pkg::cmd_e'(cmd_i) == degc_pkg::CMD_SAMPLE)) begin
          state_d = degc_pkg::ST_TRD;
          cnt_d   = '0;
        end
      end
      degc_pkg::ST_TRD:  state_d = degc_pkg::ST_TUSE;
      degc_pkg::ST_TUSE: begin
        if ((cnt_q + 5'd1) >= {1'b0, stat_i.tab_n}) begin
          state_d = degc_pkg::ST_EMUL;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = degc_pkg::ST_TRD;
        end
      end
      degc_pkg::ST_EMUL: state_d = degc_pkg::ST_EUPD;
      degc_pkg::ST_EUPD: state_d = degc_pkg::ST_NORM;
      degc_pkg::ST_NORM: begin
        if (stat_i.norm_done) begin
          state_d = degc_pkg::ST_SQM;
          cnt_d   = '0;
        end
      end
      degc_pkg::ST_SQM:  state_d = degc_pkg::ST_SQU;
      degc_pkg::ST_SQU: begin
        if (cnt_q == 5'(degc_pkg::LnRounds - 1)) begin
          state_d = degc_pkg::ST_LNM;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = degc_pkg::ST_SQM;
        end
      end
      degc_pkg::ST_LNM:  state_d = degc_pkg::ST_LNU;
      degc_pkg::ST_LNU: begin
        if (stat_i.seg_n == 3'd0) begin
          state_d = degc_pkg::ST_XM;
        end else begin
          seg_d   = '0;
          cnt_d   = '0;
          state_d = degc_pkg::ST_WLD;
        end
      end
      degc_pkg::ST_WLD: begin
        if (cnt_q == 5'(degc_pkg::SplineWords)) begin
          state_d = degc_pkg::ST_SDIF;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      degc_pkg::ST_SDIF: state_d = stat_i.lin ? degc_pkg::ST_SLM : degc_pkg::ST_SQ1M;
      degc_pkg::ST_SLM:  state_d = degc_pkg::ST_SLU;
      degc_pkg::ST_SLU:  state_d = degc_pkg::ST_SACC;
      degc_pkg::ST_SQ1M: state_d = degc_pkg::ST_SQ1U;
      degc_pkg::ST_SQ1U: state_d = degc_pkg::ST_SQ2M;
      degc_pkg::ST_SQ2M: state_d = degc_pkg::ST_SQ2U;
      degc_pkg::ST_SQ2U: state_d = degc_pkg::ST_SACC;
      degc_pkg::ST_SACC: begin
        if ((3'(seg_q) + 3'd1) >= stat_i.seg_n) begin
          state_d = degc_pkg::ST_XM;
        end else begin
          seg_d   = seg_q + 2'd1;
          cnt_d   = '0;
          state_d = degc_pkg::ST_WLD;
        end
      end
      degc_pkg::ST_XM:   state_d = stat_i.x_sat ? degc_pkg::ST_XSAT : degc_pkg::ST_XT;
      degc_pkg::ST_XSAT: state_d = degc_pkg::ST_FIN;
      degc_pkg::ST_XT:   state_d = degc_pkg::ST_XFM;
      degc_pkg::ST_XFM:  state_d = degc_pkg::ST_XFU;
      degc_pkg::ST_XFU: begin
        cnt_d   = 5'(degc_pkg::HornerTerms);
        state_d = degc_pkg::ST_HM;
      end
      degc_pkg::ST_HM:   state_d = degc_pkg::ST_HV;
      degc_pkg::ST_HV:   state_d = (cnt_q == 5'd1) ? degc_pkg::ST_HE : degc_pkg::ST_HRM;
      degc_pkg::ST_HRM:  state_d = degc_pkg::ST_HRQ;
      degc_pkg::ST_HRQ:  state_d = degc_pkg::ST_HRC;
      degc_pkg::ST_HRC:  state_d = degc_pkg::ST_HE;
      degc_pkg::ST_HE: begin
        if (cnt_q == 5'd1) begin
          state_d = degc_pkg::ST_XG;
        end else begin
          cnt_d   = cnt_q - 5'd1;
          state_d = degc_pkg::ST_HM;
        end
      end
      degc_pkg::ST_XG:   state_d = degc_pkg::ST_FIN;
      degc_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = degc_pkg::ST_IDLE;
        end
      end
      default: state_d = degc_pkg::ST_IDLE;
    endcase
  end

  // Datapath command for the current state
  always_comb begin
    cmd_o.cnt = cnt_q;
    cmd_o.seg = seg_q;
    unique case (state_q)
      degc_pkg::ST_IDLE: cmd_o.op = accept ? degc_pkg::OP_ACC : degc_pkg::OP_NONE;
      degc_pkg::ST_TRD:  cmd_o.op = degc_pkg::OP_TRD;
      degc_pkg::ST_TUSE: cmd_o.op = degc_pkg::OP_TUSE;
      degc_pkg::ST_EMUL: cmd_o.op = degc_pkg::OP_EMUL;
      degc_pkg::ST_EUPD: cmd_o.op = degc_pkg::OP_EUPD;
      degc_pkg::ST_NORM: cmd_o.op = degc_pkg::OP_NORM;
      degc_pkg::ST_SQM:  cmd_o.op = degc_pkg::OP_SQM;
      degc_pkg::ST_SQU:  cmd_o.op = degc_pkg::OP_SQU;
      degc_pkg::ST_LNM:  cmd_o.op = degc_pkg::OP_LNM;
      degc_pkg::ST_LNU:  cmd_o.op = degc_pkg::OP_LNU;
      degc_pkg::ST_WLD:  cmd_o.op = degc_pkg::OP_WLD;
      degc_pkg::ST_SDIF: cmd_o.op = degc_pkg::OP_SDIF;
      degc_pkg::ST_SLM:  cmd_o.op = degc_pkg::OP_SLM;
      degc_pkg::ST_SLU:  cmd_o.op = degc_pkg::OP_SLU;
      degc_pkg::ST_SQ1M: cmd_o.op = degc_pkg::OP_SQ1M;
      degc_pkg::ST_SQ1U: cmd_o.op = degc_pkg::OP_SQ1U;
      degc_pkg::ST_SQ2M: cmd_o.op = degc_pkg::OP_SQ2M;
      degc_pkg::ST_SQ2U: cmd_o.op = degc_pkg::OP_SQ2U;
      degc_pkg::ST_SACC: cmd_o.op = degc_pkg::OP_SACC;
      degc_pkg::ST_XM:   cmd_o.op = degc_pkg::OP_XM;
      degc_pkg::ST_XSAT: cmd_o.op = degc_pkg::OP_XSAT;
      degc_pkg::ST_XT:   cmd_o.op = degc_pkg::OP_XT;
      degc_pkg::ST_XFM:  cmd_o.op = degc_pkg::OP_XFM;
      degc_pkg::ST_XFU:  cmd_o.op = degc_pkg::OP_XFU;
      degc_pkg::ST_HM:   cmd_o.op = degc_pkg::OP_HM;
      degc_pkg::ST_HV:   cmd_o.op = degc_pkg::OP_HV;
      degc_pkg::ST_HRM:  cmd_o.op = degc_pkg::OP_HRM;
      degc_pkg::ST_HRQ:  cmd_o.op = degc_pkg::OP_HRQ;
      degc_pkg::ST_HRC:  cmd_o.op = degc_pkg::OP_HRC;
      degc_pkg::ST_HE:   cmd_o.op = degc_pkg::OP_HE;
      degc_pkg::ST_XG:   cmd_o.op = degc_pkg::OP_XG;
      degc_pkg::ST_FIN:  cmd_o.op = out_free ? degc_pkg::OP_FIN : degc_pkg::OP_NONE;
      default:           cmd_o.op = degc_pkg::OP_NONE;
    endcase
  end

  // Set output valid on load, drop it when the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == degc_pkg::ST_FIN) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= degc_pkg::ST_IDLE;
      cnt_q       <= '0;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != degc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: sv/degc_dpath.sv
`default_nettype none

module degc_dpath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire degc_pkg::ctrl_cmd_t  cmd_i,
  output degc_pkg::dp_stat_t        stat_o,
  input  wire logic [1:0]           in_cmd_i,
  input  wire logic signed [23:0]   sample_i,
  input  wire logic [2:0]           entry_index_i,
  input  wire logic [3:0]           field_select_i,
  input  wire logic signed [31:0]   table_value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  output logic [23:0]               gain_o,
  output logic signed [23:0]        envelope_level_o
);

  // Round a Q16 product half up, add a word, saturate to 32 bits
  function automatic logic signed [31:0] q16_add(input logic signed [65:0] p,
                                                 input logic signed [31:0] w);
    logic signed [65:0] t;
    t = ((p + 66'sd32768) >>> 16) + $signed({{34{w[31]}}, w});
    if (t > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (t < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return t[31:0];
  endfunction

  // Configuration registers
  logic [2:0]  spline_count_q;
  logic [3:0]  attack_count_q;
  logic [3:0]  release_count_q;
  logic [22:0] min_level_q;

  // Working registers
  logic signed [23:0] env_q;
  logic signed [23:0] smp_q;
  logic               rel_q;
  logic signed [23:0] coef_q;
  logic [23:0]        y_q;
  logic [4:0]         z_q;
  logic [19:0]        frac_q;
  logic signed [31:0] lx_q;
  logic signed [31:0] w_q [degc_pkg::SplineWords];
  logic signed [31:0] d_q;
  logic signed [31:0] a_q;
  logic signed [34:0] sum_q;
  logic signed [5:0]  k_q;
  logic [19:0]        f_q;
  logic [29:0]        ye_q;
  logic [31:0]        e_q;
  logic [30:0]        v_q;
  logic [30:0]        q_q;
  logic [4:0]         r_q;
  logic [23:0]        res_q;
  logic signed [65:0] prod_q;
  logic [23:0]        gain_q;
  logic signed [23:0] envl_q;

  // Memory ports
  logic        tab_we_lvl, tab_we_coef, spl_we;
  logic [3:0]  tab_waddr, tab_raddr;
  logic [5:0]  spl_waddr, spl_raddr;
  logic [23:0] lvl_rdata, coef_rdata;
  logic [31:0] spl_rdata;

  // Combinational intermediates
  logic               acc_write;
  degc_pkg::cmd_e     in_cmd;
  logic [3:0]         n;
  logic signed [32:0] mul_a, mul_b;
  logic signed [24:0] diff;
  logic signed [25:0] lval;
  logic signed [65:0] eu_t, eu_ne;
  logic signed [23:0] ne;
  logic [23:0]        mag, lo_lvl;
  logic [24:0]        sq_t;
  logic signed [65:0] ln_t, xt_t;
  logic signed [32:0] dif33;
  logic               lo_hit, hi_hit, x_big, x_small;
  logic [34:0]        qn;
  logic [31:0]        rem;
  logic [5:0]         sh;
  logic [34:0]        g;
  logic [3:0]         att_n, rel_n;

  assign in_cmd    = degc_pkg::cmd_e'(in_cmd_i);
  assign acc_write = (cmd_i.op == degc_pkg::OP_ACC);
  assign n         = cmd_i.cnt[3:0];

  // Table and spline word writes on an accepted write request
  assign tab_we_lvl  = acc_write && (in_cmd == degc_pkg::CMD_ATTACK ||
                                     in_cmd == degc_pkg::CMD_RELEASE) &&
                       (field_select_i == 4'd0);
  assign tab_we_coef = acc_write && (in_cmd == degc_pkg::CMD_ATTACK ||
                                     in_cmd == degc_pkg::CMD_RELEASE) &&
                       (field_select_i == 4'd1);
  assign tab_waddr   = {in_cmd == degc_pkg::CMD_RELEASE, entry_index_i};
  assign tab_raddr   = {rel_q, cmd_i.cnt[2:0]};
  assign spl_we      = acc_write && (in_cmd == degc_pkg::CMD_SPLINE) &&
                       ({1'b0, entry_index_i} < 4'(degc_pkg::MaxSegments)) &&
                       (field_select_i < 4'(degc_pkg::SplineWords));
  assign spl_waddr   = 6'({entry_index_i[1:0], 3'b000}) + 6'(entry_index_i[1:0]) +
                       6'(field_select_i);
  assign spl_raddr   = 6'({cmd_i.seg, 3'b000}) + 6'(cmd_i.seg) +
                       ((cmd_i.cnt < 5'(degc_pkg::SplineWords)) ? 6'(cmd_i.cnt) : 6'd0);

  degc_ram #(.Width(24), .Depth(degc_pkg::TableDepth)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we_lvl),
    .waddr_i (tab_waddr),
    .wdata_i (table_value_i[23:0]),
    .raddr_i (tab_raddr),
    .rdata_o (lvl_rdata)
  );

  degc_ram #(.Width(24), .Depth(degc_pkg::TableDepth)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we_coef),
    .waddr_i (tab_waddr),
    .wdata_i (table_value_i[23:0]),
    .raddr_i (tab_raddr),
    .rdata_o (coef_rdata)
  );

  degc_ram #(.Width(32), .Depth(degc_pkg::SplineDepth)) u_spl_ram (
    .clk_i   (clk_i),
    .we_i    (spl_we),
    .waddr_i (spl_waddr),
    .wdata_i (table_value_i),
    .raddr_i (spl_raddr),
    .rdata_o (spl_rdata)
  );

  // Segment branch and exp range checks
  assign lo_hit  = (lx_q <= w_q[4]);
  assign hi_hit  = (lx_q >= w_q[5]);
  assign x_big   = (sum_q >= 35'sd196608);
  assign x_small = (sum_q < -35'sd1048576);

  // Clamp entry counts and segment count, report status to the controller
  always_comb begin
    att_n = (attack_count_q == 4'd0) ? 4'd1 :
            (attack_count_q > 4'(degc_pkg::MaxReactions)) ? 4'(degc_pkg::MaxReactions) :
            attack_count_q;
    rel_n = (release_count_q == 4'd0) ? 4'd1 :
            (release_count_q > 4'(degc_pkg::MaxReactions)) ? 4'(degc_pkg::MaxReactions) :
            release_count_q;
    stat_o.tab_n     = rel_q ? rel_n : att_n;
    stat_o.seg_n     = (spline_count_q > 3'(degc_pkg::MaxSegments)) ?
                       3'(degc_pkg::MaxSegments) : spline_count_q;
    stat_o.norm_done = y_q[23];
    stat_o.lin       = lo_hit || hi_hit;
    stat_o.x_sat     = x_big || x_small;
  end

  // Shared multiplier operand select
  always_comb begin
    diff  = {smp_q[23], smp_q} - {env_q[23], env_q};
    lval  = {6'd0 - {1'b0, z_q}, frac_q};
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      degc_pkg::OP_EMUL: begin
        mul_a = {{8{diff[24]}}, diff};
        mul_b = {{9{coef_q[23]}}, coef_q};
      end
      degc_pkg::OP_SQM: begin
        mul_a = {9'd0, y_q};
        mul_b = {9'd0, y_q};
      end
      degc_pkg::OP_LNM: begin
        mul_a = {{7{lval[25]}}, lval};
        mul_b = {2'd0, degc_pkg::Ln2Q30};
      end
      degc_pkg::OP_SLM: begin
        mul_a = lo_hit ? {w_q[2][31], w_q[2]} : {w_q[3][31], w_q[3]};
        mul_b = {d_q[31], d_q};
      end
      degc_pkg::OP_SQ1M: begin
        mul_a = {w_q[6][31], w_q[6]};
        mul_b = {lx_q[31], lx_q};
      end
      degc_pkg::OP_SQ2M: begin
        mul_a = {a_q[31], a_q};
        mul_b = {lx_q[31], lx_q};
      end
      degc_pkg::OP_XM: begin
        mul_a = {{11{sum_q[21]}}, sum_q[21:0]};
        mul_b = {2'd0, degc_pkg::Log2eQ30};
      end
      degc_pkg::OP_XFM: begin
        mul_a = {13'd0, f_q};
        mul_b = {2'd0, degc_pkg::Ln2Q30};
      end
      degc_pkg::OP_HM: begin
        mul_a = {3'd0, ye_q};
        mul_b = {1'b0, e_q};
      end
      degc_pkg::OP_HRM: begin
        mul_a = {2'd0, v_q};
        mul_b = {1'b0, degc_pkg::recip(n)};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Result-side arithmetic of each step
  always_comb begin
    eu_t   = (prod_q + 66'sd4194304) >>> 23;
    eu_ne  = eu_t + {{42{env_q[23]}}, env_q};
    if (eu_ne > 66'sd8388607) begin
      ne = 24'sh7F_FFFF;
    end else if (eu_ne < -66'sd8388608) begin
      ne = 24'sh80_0000;
    end else begin
      ne = eu_ne[23:0];
    end
    mag    = ne[23] ? (24'd0 - ne) : ne;
    lo_lvl = (min_level_q == 23'd0) ? 24'd1 : {1'b0, min_level_q};
    sq_t   = prod_q[47:23];
    ln_t   = prod_q + 66'sd8589934592;
    xt_t   = (prod_q + 66'sd33554432) >>> 26;
    dif33  = {lx_q[31], lx_q} - {w_q[0][31], w_q[0]};
    qn     = 35'(q_q) * 35'(n);
    rem    = {1'b0, v_q} - qn[31:0];
    sh     = 6'd10 - k_q;
    g      = (35'(e_q) + (35'd1 << (sh - 6'd1))) >> sh;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spline_count_q  <= 3'd0;
      attack_count_q  <= 4'd1;
      release_count_q <= 4'd1;
      min_level_q     <= 23'd1;
    end else if (cfg_we_i) begin
      unique case (degc_pkg::cfg_idx_e'(cfg_index_i))
        degc_pkg::CFG_SPLINE_COUNT:  spline_count_q  <= cfg_data_i[2:0];
        degc_pkg::CFG_ATTACK_COUNT:  attack_count_q  <= cfg_data_i[3:0];
        degc_pkg::CFG_RELEASE_COUNT: release_count_q <= cfg_data_i[3:0];
        degc_pkg::CFG_MIN_LEVEL:     min_level_q     <= cfg_data_i[22:0];
        default:                     min_level_q     <= min_level_q;
      endcase
    end
  end

  // Envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (cmd_i.op == degc_pkg::OP_EUPD) begin
      env_q <= ne;
    end
  end

  // Datapath registers, advanced by the current operation
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      degc_pkg::OP_ACC: begin
        smp_q <= sample_i;
        rel_q <= !(sample_i > env_q);
      end
      degc_pkg::OP_TUSE: begin
        if (cmd_i.cnt == 5'd0 || env_q >= $signed(lvl_rdata)) begin
          coef_q <= coef_rdata;
        end
      end
      degc_pkg::OP_EUPD: begin
        y_q    <= (mag < lo_lvl) ? lo_lvl : mag;
        z_q    <= '0;
        frac_q <= '0;
      end
      degc_pkg::OP_NORM: begin
        if (!y_q[23]) begin
          y_q <= {y_q[22:0], 1'b0};
          z_q <= z_q + 5'd1;
        end
      end
      degc_pkg::OP_SQU: begin
        y_q    <= sq_t[24] ? sq_t[24:1] : sq_t[23:0];
        frac_q <= {frac_q[18:0], sq_t[24]};
      end
      degc_pkg::OP_LNU: begin
        lx_q  <= ln_t[65:34];
        sum_q <= '0;
      end
      degc_pkg::OP_WLD: begin
        for (int k = 0; k < degc_pkg::SplineWords; k++) begin
          if (cmd_i.cnt == 5'(k + 1)) begin
            w_q[k] <= spl_rdata;
          end
        end
      end
      degc_pkg::OP_SDIF: begin
        if (dif33 > 33'sd2147483647) begin
          d_q <= 32'sh7FFF_FFFF;
        end else if (dif33 < -33'sd2147483648) begin
          d_q <= 32'sh8000_0000;
        end else begin
          d_q <= dif33[31:0];
        end
      end
      degc_pkg::OP_SLU:  a_q <= q16_add(prod_q, w_q[1]);
      degc_pkg::OP_SQ1U: a_q <= q16_add(prod_q, w_q[7]);
      degc_pkg::OP_SQ2U: a_q <= q16_add(prod_q, w_q[8]);
      degc_pkg::OP_SACC: sum_q <= sum_q + {{3{a_q[31]}}, a_q};
      degc_pkg::OP_XSAT: res_q <= x_big ? degc_pkg::GainMax : 24'd0;
      degc_pkg::OP_XT: begin
        k_q <= xt_t[25:20];
        f_q <= xt_t[19:0];
      end
      degc_pkg::OP_XFU: begin
        ye_q <= prod_q[49:20];
        e_q  <= degc_pkg::OneQ30;
      end
      degc_pkg::OP_HV: begin
        v_q <= prod_q[60:30];
        if (n == 4'd1) begin
          q_q <= prod_q[60:30];
          r_q <= '0;
        end
      end
      degc_pkg::OP_HRQ: q_q <= prod_q[62:32];
      degc_pkg::OP_HRC: r_q <= rem[4:0];
      degc_pkg::OP_HE:  e_q <= degc_pkg::OneQ30 + 32'(q_q) + 32'(r_q >= 5'(n));
      degc_pkg::OP_XG:  res_q <= (g > 35'(degc_pkg::GainMax)) ? degc_pkg::GainMax : g[23:0];
      degc_pkg::OP_FIN: begin
        gain_q <= res_q;
        envl_q <= env_q;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign gain_o           = gain_q;
  assign envelope_level_o = envl_q;

endmodule

`default_nettype wire

// File: sv/dynamics_envelope_gain_curve_unit.sv
// Compressor envelope follower with a soft-knee gain curve.
// Input channel (in_valid_i / in_stall_o): one request per item. cmd_i selects a
// sidechain sample or a write into the spline words or the attack/release tables.
// A write leaves the unit idle and gives no result. A sample walks the chosen table
// (a read and a use step per valid entry), updates the envelope, takes the log by one
// normalize shift per cycle and 20 squaring rounds, evaluates each active spline
// segment (nine words read from the spline memory each), then the exp by a 10-step
// Horner series with reciprocal division. The steps share one 33x33 multiplier;
// one sample is in work at a time, the next is taken the cycle after loading.
// Output channel (out_valid_o / out_stall_i): gain_o and envelope_level_o stay
// held while the receiver stalls; a finished sample waits for the register.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready; write it while idle.
// Reset clears the envelope and loads the register defaults; table and spline
// contents are undefined until written.
`default_nettype none

module dynamics_envelope_gain_curve_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [23:0] sample_i,
  input  wire logic [2:0]         entry_index_i,
  input  wire logic [3:0]         field_select_i,
  input  wire logic signed [31:0] table_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [23:0]             gain_o,
  output logic signed [23:0]      envelope_level_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  degc_pkg::ctrl_cmd_t ctrl_cmd;
  degc_pkg::dp_stat_t  dp_stat;

  assign cfg_ready_o = 1'b1;

  degc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (ctrl_cmd)
  );

  degc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .stat_o           (dp_stat),
    .in_cmd_i         (cmd_i),
    .sample_i         (sample_i),
    .entry_index_i    (entry_index_i),
    .field_select_i   (field_select_i),
    .table_value_i    (table_value_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .gain_o           (gain_o),
    .envelope_level_o (envelope_level_o)
  );

`ifndef SYNTHESIS
  // An accepted sample blocks further requests while it is worked on
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i == degc_pkg::CMD_SAMPLE) |=> in_stall_o)
    else $error("sample accepted without going busy");

  // A write request never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i != degc_pkg::CMD_SAMPLE && !out_valid_o)
    |=> !out_valid_o)
    else $error("write request produced a result");

  // A new result only appears while a sample was in work
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a sample in work");
`endif

endmodule

`default_nettype wire

// File: tb/tb_dynamics_envelope_gain_curve_unit.sv
`default_nettype none

module tb_dynamics_envelope_gain_curve_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected compressor output for one sample
  typedef struct {
    logic [23:0]        gain;
    logic signed [23:0] level;
  } gain_pair_t;

  // Envelope and gain-curve predictor plus the queue of expected outputs
  class gain_scoreboard;
    longint envelope;
    longint atk_level[degc_pkg::MaxReactions];
    longint atk_coef[degc_pkg::MaxReactions];
    longint rel_level[degc_pkg::MaxReactions];
    longint rel_coef[degc_pkg::MaxReactions];
    longint spline[degc_pkg::SplineDepth];
    int unsigned spline_n, atk_n, rel_n, floor_level;
    gain_pair_t pending[$];
    int errors;

    function new();
      envelope = 0;
      spline_n = 0;
      atk_n = 1;
      rel_n = 1;
      floor_level = 1;
      errors = 0;
      foreach (atk_level[i]) begin
        atk_level[i] = 0;
        atk_coef[i] = 0;
        rel_level[i] = 0;
        rel_coef[i] = 0;
      end
      foreach (spline[i]) spline[i] = 0;
    endfunction

    function void set_reg(degc_pkg::cfg_idx_e idx, logic [31:0] val);
      case (idx)
        degc_pkg::CFG_SPLINE_COUNT:  spline_n = 32'(val[2:0]);
        degc_pkg::CFG_ATTACK_COUNT:  atk_n = 32'(val[3:0]);
        degc_pkg::CFG_RELEASE_COUNT: rel_n = 32'(val[3:0]);
        degc_pkg::CFG_MIN_LEVEL:     floor_level = 32'(val[22:0]);
        default: ;
      endcase
    endfunction

    static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function longint mul16(longint a, longint b);
      return (a * b + 32768) >>> 16;
    endfunction

    static function longint ln16(int unsigned x);
      int p;
      longint unsigned y;
      longint frac, l;
      p = 23;
      frac = 0;
      while (p > 0 && x[p] == 1'b0) p--;
      y = longint'(x) << (23 - p);
      for (int i = 19; i >= 0; i--) begin
        y = (y * y) >> 23;
        if (y >= (64'd1 << 24)) begin
          y >>= 1;
          frac |= 64'sd1 << i;
        end
      end
      l = longint'(p - 23) * 1048576 + frac;
      return (l * longint'(degc_pkg::Ln2Q30) + (64'sd1 << 33)) >>> 34;
    endfunction

    static function longint exp20(longint s);
      longint t20, k, f, y, e, g;
      int sh;
      if (s >= 3 * 65536) return 24'hFFFFFF;
      if (s < -16 * 65536) return 0;
      t20 = (s * longint'(degc_pkg::Log2eQ30) + (64'sd1 << 25)) >>> 26;
      k = t20 >>> 20;
      f = t20 - k * 1048576;
      y = (f * longint'(degc_pkg::Ln2Q30)) >> 20;
      e = longint'(degc_pkg::OneQ30);
      for (int n = 10; n >= 1; n--) e = longint'(degc_pkg::OneQ30) + ((y * e) >> 30) / n;
      sh = int'(10 - k);
      g = (e + (64'sd1 << (sh - 1))) >> sh;
      if (g > 24'hFFFFFF) g = 24'hFFFFFF;
      return g;
    endfunction

    function longint curve(int j, longint lx);
      int b;
      b = j * degc_pkg::SplineWords;
      if (lx <= spline[b + 4])
        return sat32(spline[b + 1] + mul16(spline[b + 2], sat32(lx - spline[b])));
      if (lx >= spline[b + 5])
        return sat32(spline[b + 1] + mul16(spline[b + 3], sat32(lx - spline[b])));
      return sat32(mul16(sat32(mul16(spline[b + 6], lx) + spline[b + 7]), lx)
                   + spline[b + 8]);
    endfunction

    // Note one accepted request and queue its output when it is a sample
    function void note_request(degc_pkg::cmd_e cmd, logic signed [23:0] smp,
                               logic [2:0] idx, logic [3:0] fs,
                               logic signed [31:0] val);
      longint coef, ne, mag, sum, lx;
      int unsigned n;
      gain_pair_t r;
      case (cmd)
        degc_pkg::CMD_SAMPLE: begin
          n = (smp > envelope) ? atk_n : rel_n;
          if (n < 1) n = 1;
          if (n > degc_pkg::MaxReactions) n = degc_pkg::MaxReactions;
          coef = (smp > envelope) ? atk_coef[0] : rel_coef[0];
          for (int i = 1; i < n; i++) begin
            if (smp > envelope) begin
              if (envelope >= atk_level[i]) coef = atk_coef[i];
            end else if (envelope >= rel_level[i]) coef = rel_coef[i];
          end
          ne = envelope + (((longint'(smp) - envelope) * coef + (64'sd1 << 22)) >>> 23);
          if (ne > 64'sd8388607) ne = 64'sd8388607;
          if (ne < -64'sd8388608) ne = -64'sd8388608;
          envelope = ne;
          mag = ne < 0 ? -ne : ne;
          if (mag < ((floor_level == 0) ? 1 : floor_level))
            mag = (floor_level == 0) ? 1 : floor_level;
          lx = ln16(32'(mag));
          sum = 0;
          n = spline_n > degc_pkg::MaxSegments ? degc_pkg::MaxSegments : spline_n;
          for (int j = 0; j < n; j++) sum += curve(j, lx);
          r.gain = 24'(exp20(sum));
          r.level = 24'(ne);
          pending.push_back(r);
        end
        degc_pkg::CMD_SPLINE: if (idx < degc_pkg::MaxSegments && fs < degc_pkg::SplineWords)
          spline[idx * degc_pkg::SplineWords + fs] = val;
        default: if (fs < 2) begin
          if (cmd == degc_pkg::CMD_ATTACK) begin
            if (fs == 0) atk_level[idx] = longint'($signed(val[23:0]));
            else atk_coef[idx] = longint'($signed(val[23:0]));
          end else begin
            if (fs == 0) rel_level[idx] = longint'($signed(val[23:0]));
            else rel_coef[idx] = longint'($signed(val[23:0]));
          end
        end
      endcase
    endfunction

    // Compare one output against the oldest expectation
    function void check_output(logic [23:0] g, logic signed [23:0] lv);
      gain_pair_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output gain=%h level=%h", $time, g, lv);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (g !== r.gain) begin
        $display("%0t: gain expected %h actual %h", $time, r.gain, g);
        errors++;
      end
      if (lv !== r.level) begin
        $display("%0t: level expected %h actual %h", $time, r.level, lv);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_valid_i, cfg_ready_o;
  logic [1:0] cmd_i, cfg_index_i;
  logic signed [23:0] sample_i, envelope_level_o;
  logic [2:0] entry_index_i;
  logic [3:0] field_select_i;
  logic signed [31:0] table_value_i;
  logic [23:0] gain_o;
  logic [31:0] cfg_data_i;

  int send_idle_pct, recv_idle_pct;
  int hold_off_reqs;
  int hold_off_seen;
  int hold_off_cycles;
  gain_scoreboard sb;

  dynamics_envelope_gain_curve_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .sample_i, .entry_index_i,
    .field_select_i, .table_value_i, .out_valid_o, .out_stall_i, .gain_o,
    .envelope_level_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Drive the request channel and note accepted requests
  task automatic send_request(degc_pkg::cmd_e cmd, logic signed [23:0] smp,
                              logic [2:0] idx, logic [3:0] fs,
                              logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    sample_i <= smp;
    entry_index_i <= idx;
    field_select_i <= fs;
    table_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, smp, idx, fs, val);
  endtask

  // Wait until every queued output arrived, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_reg(degc_pkg::cfg_idx_e idx, logic [31:0] val);
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] random_word(int w, bit extreme);
    if (extreme) return 32'($urandom);
    case (w)
      2, 3: return $signed(32'($urandom_range(131072))) - 32'sd65536;
      4: return -$signed(32'($urandom_range(600000)));
      5: return -$signed(32'($urandom_range(300000)));
      6, 7: return $signed(32'($urandom_range(40000))) - 32'sd20000;
      default: return $signed(32'($urandom_range(400000))) - 32'sd200000;
    endcase
  endfunction

  // Load all tables and spline words so no unwritten entry is read
  task automatic load_tables(bit extreme);
    logic signed [23:0] lvl;
    for (int i = 0; i < degc_pkg::MaxReactions; i++) begin
      lvl = (i == 0) ? -24'sd8388608 : $signed(24'($urandom_range(8388607)));
      send_request(degc_pkg::CMD_ATTACK, 24'sd0, 3'(i), 4'd0, 32'(lvl));
      send_request(degc_pkg::CMD_ATTACK, 24'sd0, 3'(i), 4'd1,
                   extreme ? ((i % 2) ? 32'h7FFFFF : 32'hFF800000)
                           : 32'($urandom_range(8388607)));
      send_request(degc_pkg::CMD_RELEASE, 24'sd0, 3'(i), 4'd0,
                   32'($signed(24'($urandom))));
      send_request(degc_pkg::CMD_RELEASE, 24'sd0, 3'(i), 4'd1,
                   extreme ? 32'h00800000 : 32'($urandom_range(8388607)));
    end
    for (int j = 0; j < degc_pkg::MaxSegments; j++) begin
      for (int w = 0; w < degc_pkg::SplineWords; w++)
        send_request(degc_pkg::CMD_SPLINE, 24'sd0, 3'(j), 4'(w), random_word(w, extreme));
    end
  endtask

  // Random mix of samples and noisy writes
  task automatic random_phase(int items);
    int c;
    for (int n = 0; n < items; n++) begin
      c = $urandom_range(99);
      if (c < 80)
        send_request(degc_pkg::CMD_SAMPLE, 24'($urandom), 3'($urandom), 4'($urandom),
                     32'($urandom));
      else if (c < 88)
        send_request(degc_pkg::CMD_SPLINE, 24'sd0, 3'($urandom), 4'($urandom_range(15)),
                     random_word(n % 9, 0));
      else
        send_request(degc_pkg::cmd_e'($urandom_range(2, 3)), 24'($urandom),
                     3'($urandom), 4'($urandom_range(15)), 32'($urandom));
    end
  endtask

  // Receiver: random stalls and a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_cycles <= 2000;
      out_stall_i <= 1'b1;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_output(gain_o, envelope_level_o);
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = degc_pkg::CMD_SAMPLE;
    sample_i = '0;
    entry_index_i = '0;
    field_select_i = '0;
    table_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = degc_pkg::CFG_SPLINE_COUNT;
    cfg_data_i = '0;
    hold_off_reqs = 0;
    send_idle_pct = 23;
    recv_idle_pct = 78;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes with all tables loaded
    load_tables(1);
    write_reg(degc_pkg::CFG_SPLINE_COUNT, 32'd4);
    write_reg(degc_pkg::CFG_ATTACK_COUNT, 32'd8);
    write_reg(degc_pkg::CFG_RELEASE_COUNT, 32'd0);
    write_reg(degc_pkg::CFG_MIN_LEVEL, 32'd0);
    send_request(degc_pkg::CMD_SAMPLE, 24'sh7FFFFF, 3'd0, 4'd0, 32'sd0);
    send_request(degc_pkg::CMD_SAMPLE, -24'sd8388608, 3'd0, 4'd0, 32'sd0);
    send_request(degc_pkg::CMD_SAMPLE, 24'sd0, 3'd0, 4'd0, 32'sd0);
    send_request(degc_pkg::CMD_SPLINE, 24'sd0, 3'd7, 4'd15, 32'h7FFFFFFF);
    send_request(degc_pkg::CMD_ATTACK, 24'sd0, 3'd7, 4'd2, 32'h80000000);
    send_request(degc_pkg::CMD_SAMPLE, 24'sd1, 3'd0, 4'd0, 32'sd0);
    drain();

    // Random phase one: fast sender, busy receiver
    load_tables(0);
    write_reg(degc_pkg::CFG_SPLINE_COUNT, 32'd2);
    write_reg(degc_pkg::CFG_ATTACK_COUNT, 32'd4);
    write_reg(degc_pkg::CFG_RELEASE_COUNT, 32'd15);
    write_reg(degc_pkg::CFG_MIN_LEVEL, 32'h7FFFFF);
    random_phase(150);
    drain();

    // Random phase two: now the other way round
    send_idle_pct = 78;
    recv_idle_pct = 23;
    write_reg(degc_pkg::CFG_SPLINE_COUNT, 32'd7);
    write_reg(degc_pkg::CFG_ATTACK_COUNT, 32'd1);
    write_reg(degc_pkg::CFG_RELEASE_COUNT, 32'd8);
    write_reg(degc_pkg::CFG_MIN_LEVEL, 32'd1000);
    random_phase(150);
    drain();

    // Long receiver hold-off while requests keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_reqs++;
    write_reg(degc_pkg::CFG_SPLINE_COUNT, 32'd0);
    random_phase(100);
    drain();
    load_tables(0);
    write_reg(degc_pkg::CFG_SPLINE_COUNT, 32'd3);
    write_reg(degc_pkg::CFG_MIN_LEVEL, 32'($urandom_range(1, 8388607)));
    random_phase(250);
    drain();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

`default_nettype wire
